### hw/rtl/ial_pkg.sv
package ial_pkg;

   // request kinds
   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_SEARCH = 3'd3,
      MODE_POP    = 3'd4
   } mode_type;

   // result status codes
   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_RANGE    = 3'd3,
      STAT_NOTFOUND = 3'd4
   } stat_type;

   // controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic     apply;
      mode_type mode;
   } cell_cmd_type;

   // register map
   localparam int CSR_AW = 2;
   localparam logic [CSR_AW-1:0] ADDR_CAPACITY = 2'd0;
   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

### hw/rtl/ial_cell.sv
module ial_cell #(
   parameter int POS   = 0,
   parameter int WIDTH = 32,
   parameter int XW    = 5
) (
   input  logic                  clock,
   input  ial_pkg::cell_cmd_type cmd,
   input  logic [XW-1:0]         idx,
   input  logic [XW-1:0]         count,
   input  logic [WIDTH-1:0]      key,
   input  logic [WIDTH-1:0]      left_word,
   input  logic [WIDTH-1:0]      right_word,
   output logic [WIDTH-1:0]      word,
   output logic                  match
);

   localparam logic [XW-1:0] POS_V  = XW'(POS);
   localparam logic [XW-1:0] POS_NX = XW'(POS + 1);

   logic [WIDTH-1:0] word_ff;
   logic [WIDTH-1:0] word_in;

   // pick this position's next word from the broadcast command
   always_comb begin
      word_in = word_ff;
      if (cmd.apply) begin
         case (cmd.mode)
            ial_pkg::MODE_APPEND: begin
               if (POS_V == count) word_in = key;
            end
            ial_pkg::MODE_INSERT: begin
               if (POS_V == idx) word_in = key;
               else if (POS_V > idx && POS_V <= count) word_in = left_word;
            end
            ial_pkg::MODE_REMOVE: begin
               if (POS_V >= idx && POS_NX < count) word_in = right_word;
            end
            default: begin
               word_in = word_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word  = word_ff;
   assign match = (word_ff == key);

endmodule

### hw/rtl/ial_ctrl.sv
module ial_ctrl #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int CW = $clog2(DEPTH + 1),
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int XW = (CW > 5) ? CW : 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ial_pkg::CAP_W-1:0]     capacity,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_mode,
   input  logic [4:0]                    req_index,
   input  logic signed [31:0]            req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic signed [31:0]            rsp_removed_value,
   output logic [3:0]                    rsp_found_index,
   output logic [4:0]                    rsp_entry_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,
   input  logic [DEPTH-1:0][WIDTH-1:0]   words,
   input  logic [DEPTH-1:0]              match_vec,
   output ial_pkg::cell_cmd_type         cmd,
   output logic [XW-1:0]                 idx_x,
   output logic [XW-1:0]                 cnt_x,
   output logic [WIDTH-1:0]              key
);

   ial_pkg::state_type state_ff, state_in;
   ial_pkg::mode_type  mode_ff;
   logic [4:0]         idx_ff;
   logic [WIDTH-1:0]   key_ff, key_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   ial_pkg::stat_type  status_ff;
   logic [31:0]        removed_ff;
   logic [3:0]         found_ff;
   logic [4:0]         ecount_ff;
   logic               empty_ff, full_ff;

   logic               accept, out_free, finish, done, do_apply;
   logic [XW-1:0]      eff_cap, nc, pos_x;
   logic               full_now, empty_now, hit, last;
   logic [63:0]        val_ext, rem_ext;
   logic [WIDTH-1:0]   sel_word;
   ial_pkg::stat_type  st;
   logic [31:0]        rem;
   logic [3:0]         fnd;

   assign accept   = req_valid && (state_ff == ial_pkg::S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // word kept in its low WIDTH bits, high part zero
   assign val_ext = {32'd0, req_value};
   assign key_in  = val_ext[WIDTH-1:0];

   // capacity saturates at the built depth
   assign cnt_x     = XW'(count_ff);
   assign idx_x     = XW'(idx_ff);
   assign pos_x     = XW'(pos_ff);
   assign eff_cap   = (XW'(capacity) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(capacity);
   assign full_now  = (cnt_x >= eff_cap);
   assign empty_now = (count_ff == '0);

   // search walks the match flags one position per cycle
   assign hit  = match_vec[pos_ff];
   assign last = ((pos_x + XW'(1)) == cnt_x);

   assign sel_word = words[idx_x[AW-1:0]];
   assign rem_ext  = 64'(sel_word);

   // outcome of the pending item
   always_comb begin
      st       = ial_pkg::STAT_OK;
      rem      = '0;
      fnd      = '0;
      nc       = cnt_x;
      do_apply = 1'b0;
      done     = 1'b1;
      case (mode_ff)
         ial_pkg::MODE_APPEND: begin
            if (full_now) st = ial_pkg::STAT_FULL;
            else begin
               do_apply = 1'b1;
               nc       = cnt_x + XW'(1);
            end
         end
         ial_pkg::MODE_INSERT: begin
            if (full_now) st = ial_pkg::STAT_FULL;
            else if (idx_x > cnt_x) st = ial_pkg::STAT_RANGE;
            else begin
               do_apply = 1'b1;
               nc       = cnt_x + XW'(1);
            end
         end
         ial_pkg::MODE_REMOVE: begin
            if (empty_now) st = ial_pkg::STAT_EMPTY;
            else if (idx_x >= cnt_x) st = ial_pkg::STAT_RANGE;
            else begin
               rem      = rem_ext[31:0];
               do_apply = 1'b1;
               nc       = cnt_x - XW'(1);
            end
         end
         ial_pkg::MODE_SEARCH: begin
            if (empty_now) st = ial_pkg::STAT_EMPTY;
            else if (hit) fnd = pos_x[3:0];
            else begin
               st   = ial_pkg::STAT_NOTFOUND;
               done = last;
            end
         end
         ial_pkg::MODE_POP: begin
            if (empty_now) st = ial_pkg::STAT_EMPTY;
            else nc = cnt_x - XW'(1);
         end
         default: begin
            st = ial_pkg::STAT_OK;
         end
      endcase
   end

   // sequencer: accept, then execute or scan until the result is stored
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      finish       = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ial_pkg::S_IDLE: begin
            if (accept) begin
               state_in = ial_pkg::S_EXEC;
               pos_in   = '0;
            end
         end
         ial_pkg::S_EXEC: begin
            if (done && out_free) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               count_in     = CW'(nc);
               state_in     = ial_pkg::S_IDLE;
            end else if (!done) begin
               pos_in = pos_ff + AW'(1);
            end
         end
         default: begin
            state_in = ial_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ial_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (accept) begin
         mode_ff <= ial_pkg::mode_type'(req_mode);
         idx_ff  <= req_index;
         key_ff  <= key_in;
      end
      if (finish) begin
         status_ff  <= st;
         removed_ff <= rem;
         found_ff   <= fnd;
         ecount_ff  <= nc[4:0];
         empty_ff   <= (nc == '0);
         full_ff    <= (nc >= eff_cap);
      end
   end

   assign cmd.apply = finish && do_apply;
   assign cmd.mode  = mode_ff;
   assign key       = key_ff;

   assign req_stall         = (state_ff != ial_pkg::S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_found_index   = found_ff;
   assign rsp_entry_count   = ecount_ff;
   assign rsp_is_empty      = empty_ff;
   assign rsp_is_full       = full_ff;

endmodule

### hw/rtl/indexed_array_list.sv
// Ordered list of up to DEPTH words held in a row of cells, one word per cell.
// Requests: append, insert at index, remove at index (word returned), search
// for first match, pop last. Each item returns one result with status, entry
// count and empty/full flags. Append, insert, remove and pop are accepted in
// the idle state and finished in the execute state, where the result register
// is written and, for all but pop, the cells shift or load at once. Search
// stays in the execute state while the per-cell match flags are walked one
// position per cycle, up to the first match or the last entry. An item is not
// accepted until the previous one is in the result register; a stalled result
// delays completion. capacity (address 0) is saturated to DEPTH.
module indexed_array_list #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ial_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_mode,
   input  logic [4:0]                   req_index,
   input  logic signed [31:0]           req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic signed [31:0]           rsp_removed_value,
   output logic [3:0]                   rsp_found_index,
   output logic [4:0]                   rsp_entry_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > 5) ? CW : 5;

   logic [ial_pkg::CAP_W-1:0]  cap_ff;
   logic [DEPTH-1:0][WIDTH-1:0] words;
   logic [DEPTH-1:0]            match_vec;
   ial_pkg::cell_cmd_type       cmd;
   logic [XW-1:0]               idx_x, cnt_x;
   logic [WIDTH-1:0]            key;
   logic                        cap_wr;

   // capacity register
   assign csr_pready = 1'b1;
   assign cap_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr == ial_pkg::ADDR_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= ial_pkg::CAP_RESET;
      else if (cap_wr) cap_ff <= csr_pwdata[ial_pkg::CAP_W-1:0];
   end

   assign csr_prdata = (csr_paddr == ial_pkg::ADDR_CAPACITY) ?
                       32'(cap_ff) : 32'd0;

   ial_ctrl #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .capacity          (cap_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_index         (req_index),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_found_index   (rsp_found_index),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full),
      .words             (words),
      .match_vec         (match_vec),
      .cmd               (cmd),
      .idx_x             (idx_x),
      .cnt_x             (cnt_x),
      .key               (key)
   );

   // row of cells, each linked to its neighbors; the end cells see zero outside
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WIDTH-1:0] left_w, right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = words[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = words[g+1];
      end

      ial_cell #(
         .POS   (g),
         .WIDTH (WIDTH),
         .XW    (XW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .idx        (idx_x),
         .count      (cnt_x),
         .key        (key),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (words[g]),
         .match      (match_vec[g])
      );
   end

endmodule

### hw/rtl/ial_checker.sv
module ial_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [2:0]                  rsp_status,
   input logic signed [31:0]          rsp_removed_value,
   input logic [4:0]                  rsp_entry_count,
   input logic                        rsp_is_empty,
   input logic                        rsp_is_full
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_removed_value))
      else $error("result changed while stalled");

   // empty flag agrees with the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == 5'd0)))
      else $error("empty flag disagrees with count");

   // a full refusal leaves the list full
   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ial_pkg::STAT_FULL) |-> rsp_is_full)
      else $error("full status without full flag");

   // failed items return no word
   a_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ial_pkg::STAT_OK) |-> (rsp_removed_value == 32'sd0))
      else $error("word returned on a failed item");

endmodule

bind indexed_array_list ial_checker u_ial_checker (.*);
